>>> sv/dvfc_pkg.sv
// Package for the distinct value frequency counter.
// Holds table size, count limit, entry and control types, and the state codes.
// No dependencies.
package dvfc_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        count;
   } dvfc_entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic hit_any;
   } dvfc_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } dvfc_state_type;

endpackage

>>> sv/dvfc_if.sv
// Valid/ready channel interfaces for request items and response items.
// Depends on dvfc_pkg for field widths.
interface dvfc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dvfc_pkg::VALUE_W-1:0] value;
   logic                                last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface dvfc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dvfc_pkg::VALUE_W-1:0] element;
   logic [dvfc_pkg::COUNT_W-1:0]        frequency;
   logic                                final_res;
   logic                                overflow;

   modport source (output valid, output element, output frequency, output final_res,
                   output overflow, input ready);
   modport sink   (input valid, input element, input frequency, input final_res,
                   input overflow, output ready);
endinterface

>>> sv/dvfc_cell.sv
// One table cell: holds a value and its count, matches the broadcast value,
// claims it when it is the first free cell, and shifts toward the head on drain.
// Depends on dvfc_pkg.
module dvfc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  dvfc_pkg::dvfc_ctrl_type             ctrl,
   input  logic signed [dvfc_pkg::VALUE_W-1:0] req_value,
   input  logic                                prev_valid,
   input  dvfc_pkg::dvfc_entry_type            next_entry,
   output dvfc_pkg::dvfc_entry_type            entry,
   output logic                                hit
);

   logic                         valid_ff,  valid_in;
   logic [dvfc_pkg::VALUE_W-1:0] value_ff,  value_in;
   logic [dvfc_pkg::COUNT_W-1:0] count_ff,  count_in;

   assign hit = valid_ff && (value_ff == req_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctrl.shift) begin
         valid_in = next_entry.valid;
         value_in = next_entry.value;
         count_in = next_entry.count;
      end else if (ctrl.load) begin
         if (hit) begin
            if (count_ff != dvfc_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (!valid_ff && prev_valid && !ctrl.hit_any) begin
            valid_in = 1'b1;
            value_in = req_value;
            count_in = {{(dvfc_pkg::COUNT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign entry.valid = valid_ff;
   assign entry.value = value_ff;
   assign entry.count = count_ff;

endmodule

>>> sv/distinct_value_frequency_count.sv
// Distinct value frequency counter: a row of table cells plus load/drain control.
// Depends on dvfc_pkg, dvfc_if (dvfc_req_if, dvfc_rsp_if) and dvfc_cell.
//
//   channel   dir  transfer payload
//   req_ch    in   value, last
//   rsp_ch    out  element, frequency, final_res, overflow
//
// Load: one request transfer per cycle; every cell matches the value at once.
// After a last item, requests stall while the row shifts out one entry per
// response transfer from the head cell: n stored distinct values take n transfers.
// Response stalls hold the row. Reset (synchronous) empties all cells.
module distinct_value_frequency_count #(
   parameter int TABLE_ENTRIES = dvfc_pkg::TABLE_ENTRIES
) (
   input  logic           clock,
   input  logic           reset,
   dvfc_req_if.sink       req_ch,
   dvfc_rsp_if.source     rsp_ch
);

   dvfc_pkg::dvfc_state_type state_ff, state_in;
   logic                     overflow_ff, overflow_in;

   dvfc_pkg::dvfc_entry_type entries [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] hits;
   logic [TABLE_ENTRIES:0]   valid_vec;
   dvfc_pkg::dvfc_ctrl_type  ctrl;

   logic req_xfer, rsp_xfer, drain_done;

   assign req_ch.ready = (state_ff == dvfc_pkg::ST_LOAD);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid     = (state_ff == dvfc_pkg::ST_DRAIN) && entries[0].valid;
   assign rsp_ch.element   = entries[0].value;
   assign rsp_ch.frequency = entries[0].count;
   assign rsp_ch.final_res = !entries[1].valid;
   assign rsp_ch.overflow  = overflow_ff;
   assign rsp_xfer         = rsp_ch.valid && rsp_ch.ready;
   assign drain_done       = rsp_xfer && rsp_ch.final_res;

   assign ctrl.load    = req_xfer;
   assign ctrl.shift   = rsp_xfer;
   assign ctrl.hit_any = |hits;

   assign entries[TABLE_ENTRIES] = '0;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      dvfc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .req_value  (req_ch.value),
         .prev_valid ((k == 0) ? 1'b1 : entries[(k == 0) ? 0 : k-1].valid),
         .next_entry (entries[k+1]),
         .entry      (entries[k]),
         .hit        (hits[k])
      );
   end

   for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_valid
      assign valid_vec[k] = entries[k].valid;
   end

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      unique case (state_ff)
         dvfc_pkg::ST_LOAD: begin
            if (req_xfer) begin
               if (!ctrl.hit_any && entries[TABLE_ENTRIES-1].valid) begin
                  overflow_in = 1'b1;
               end
               if (req_ch.last) begin
                  state_in = dvfc_pkg::ST_DRAIN;
               end
            end
         end
         dvfc_pkg::ST_DRAIN: begin
            if (drain_done) begin
               state_in    = dvfc_pkg::ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = dvfc_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dvfc_pkg::ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // occupied cells always form a prefix of the row
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot(valid_vec + 1'b1))
      else $error("cell occupancy not contiguous");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_ch.last |=> rsp_ch.valid)
      else $error("last item did not start drain");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("load and drain overlap");

   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> req_ch.ready && !entries[0].valid && !overflow_ff)
      else $error("table not cleared after final transfer");

endmodule

>>> tb/sv/tb_distinct_value_frequency_count.sv
// Self-checking testbench for distinct_value_frequency_count: drives sets of values,
// predicts the per-set histogram and compares every response transfer field by field.
// Depends on dvfc_pkg, dvfc_if and the RTL top level.
module tb_distinct_value_frequency_count;

   typedef logic signed [dvfc_pkg::VALUE_W-1:0] value_type;

   typedef struct {
      value_type value;
      logic      last;
      int        gap;
      bit        drain_first;
   } set_item_type;

   typedef struct {
      value_type                    element;
      logic [dvfc_pkg::COUNT_W-1:0] frequency;
      logic                         final_res;
      logic                         overflow;
   } freq_result_type;

   localparam value_type VMIN           = {1'b1, {(dvfc_pkg::VALUE_W-1){1'b0}}};
   localparam value_type VMAX           = ~VMIN;
   localparam int        WATCHDOG_LIMIT = 4000;
   localparam int        LONG_HOLD      = 300;
   localparam int        SETTLE_CYCLES  = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dvfc_req_if req_chan ();
   dvfc_rsp_if rsp_chan ();

   distinct_value_frequency_count DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_chan),
      .rsp_ch (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   set_item_type    pending_items[$];
   freq_result_type expected_freqs[$];

   // predictor state
   value_type                    tally_value[dvfc_pkg::TABLE_ENTRIES];
   logic [dvfc_pkg::COUNT_W-1:0] tally_count[dvfc_pkg::TABLE_ENTRIES];
   int                           tally_used     = 0;
   bit                           tally_overflow = 1'b0;

   int mismatches    = 0;
   int results_seen  = 0;
   int idle_cycles   = 0;

   // sampled at the rising edge, used by the falling-edge drivers
   logic req_fire     = 1'b0;
   logic rsp_fire     = 1'b0;
   logic rsp_ovf_seen = 1'b0;

   // sender state
   set_item_type cur_item;
   bit           staged   = 1'b0;
   bit           offering = 1'b0;
   int           gap_left = 0;

   // receiver state
   int rsp_wait_left  = 0;
   int hold_left      = 0;
   int burst_left     = 0;
   bit long_hold_done = 1'b0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at result %0d: %s", results_seen, what);
      mismatches++;
   endtask

   task automatic count_value(input value_type v, input logic is_last);
      bit              hit;
      freq_result_type r;
      hit = 1'b0;
      for (int k = 0; k < tally_used; k++) begin
         if (!hit && tally_value[k] == v) begin
            hit = 1'b1;
            if (tally_count[k] != dvfc_pkg::COUNT_MAX)
               tally_count[k] = tally_count[k] + 1'b1;
         end
      end
      if (!hit) begin
         if (tally_used < dvfc_pkg::TABLE_ENTRIES) begin
            tally_value[tally_used] = v;
            tally_count[tally_used] = {{(dvfc_pkg::COUNT_W-1){1'b0}}, 1'b1};
            tally_used++;
         end else begin
            tally_overflow = 1'b1;
         end
      end
      if (is_last) begin
         for (int k = 0; k < tally_used; k++) begin
            r.element   = tally_value[k];
            r.frequency = tally_count[k];
            r.final_res = (k == tally_used - 1);
            r.overflow  = tally_overflow;
            expected_freqs.push_back(r);
         end
         tally_used     = 0;
         tally_overflow = 1'b0;
         for (int k = 0; k < dvfc_pkg::TABLE_ENTRIES; k++)
            tally_count[k] = '0;
      end
   endtask

   task automatic add_set(input value_type vals[$], input bit drain_first, input bit no_gaps);
      set_item_type it;
      for (int i = 0; i < vals.size(); i++) begin
         it.value       = vals[i];
         it.last        = (i == vals.size() - 1);
         it.gap         = no_gaps ? 0 : $urandom_range(0, 7);
         it.drain_first = drain_first && (i == 0);
         pending_items.push_back(it);
      end
   endtask

   // sampling, prediction, checking and watchdog
   always @(posedge clock) begin
      freq_result_type want;
      if (reset) begin
         req_fire     <= 1'b0;
         rsp_fire     <= 1'b0;
         rsp_ovf_seen <= 1'b0;
      end else begin
         req_fire     <= req_chan.valid && req_chan.ready;
         rsp_fire     <= rsp_chan.valid && rsp_chan.ready;
         rsp_ovf_seen <= rsp_chan.valid && rsp_chan.overflow;
         if (req_chan.valid && req_chan.ready)
            count_value(req_chan.value, req_chan.last);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_freqs.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer element %0d frequency %0d",
                                         rsp_chan.element, rsp_chan.frequency));
            end else begin
               want = expected_freqs.pop_front();
               if (rsp_chan.element !== want.element)
                  report_mismatch($sformatf("element %0d, want %0d",
                                            rsp_chan.element, want.element));
               if (rsp_chan.frequency !== want.frequency)
                  report_mismatch($sformatf("frequency %0d, want %0d",
                                            rsp_chan.frequency, want.frequency));
               if (rsp_chan.final_res !== want.final_res)
                  report_mismatch($sformatf("final_res %b, want %b",
                                            rsp_chan.final_res, want.final_res));
               if (rsp_chan.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow %b, want %b",
                                            rsp_chan.overflow, want.overflow));
            end
            results_seen++;
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.value <= '0;
         req_chan.last  <= 1'b0;
      end else begin
         if (req_fire)
            offering = 1'b0;
         if (!offering && !staged && pending_items.size() != 0 &&
             !(pending_items[0].drain_first && expected_freqs.size() != 0)) begin
            cur_item = pending_items.pop_front();
            gap_left = cur_item.gap;
            staged   = 1'b1;
         end
         if (staged) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               staged         = 1'b0;
               offering       = 1'b1;
               req_chan.value <= cur_item.value;
               req_chan.last  <= cur_item.last;
            end
         end
         req_chan.valid <= offering;
      end
   end

   // response receiver; one long hold once an overflowing set starts draining
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && rsp_ovf_seen) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if (burst_left != 0) begin
               burst_left--;
               rsp_wait_left = 0;
            end else begin
               rsp_wait_left = $urandom_range(0, 7);
               if ($urandom_range(0, 15) == 0)
                  burst_left = $urandom_range(8, 40);
            end
         end
         if (rsp_wait_left != 0) begin
            rsp_wait_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      value_type vals[$];
      value_type pool[$];
      int        n;
      int        random_items;
      int        set_idx;

      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.last  = 1'b0;
      rsp_chan.ready = 1'b0;

      // directed: extremes, repeats, last on a repeat
      vals = {VMIN};
      add_set(vals, 1'b0, 1'b0);
      vals = {VMAX, value_type'(0), value_type'(-1), VMAX, value_type'(0), VMAX,
              value_type'(-1)};
      add_set(vals, 1'b0, 1'b0);
      vals = {value_type'(32'h5555_5555), value_type'(32'hAAAA_AAAA), value_type'(1),
              value_type'(32'h5555_5555)};
      add_set(vals, 1'b0, 1'b1);
      vals = {VMIN, VMIN, VMIN};
      add_set(vals, 1'b0, 1'b0);

      // table exactly full, last transfer hits the first entry
      vals.delete();
      for (int k = 0; k < dvfc_pkg::TABLE_ENTRIES; k++)
         vals.push_back(value_type'(32'h0100_0000 + k * 32'h0001_0203));
      vals.push_back(vals[0]);
      add_set(vals, 1'b0, 1'b0);

      // table overflow, last value is a dropped one; sender waits for the drain first
      vals.delete();
      for (int k = 0; k < dvfc_pkg::TABLE_ENTRIES + 3; k++)
         vals.push_back(value_type'(-3 * k - 5));
      vals.push_back(vals[10]);
      vals.push_back(value_type'(32'h7000_0001));
      add_set(vals, 1'b1, 1'b0);

      // offered while the receiver holds off
      vals = {value_type'(7), value_type'(7), value_type'(-7)};
      add_set(vals, 1'b0, 1'b0);

      // random sets: short, with repeats
      random_items = 0;
      set_idx      = 0;
      while (random_items < 50) begin
         n = $urandom_range(1, 12);
         pool.delete();
         for (int k = 0; k < $urandom_range(1, 4); k++)
            pool.push_back(value_type'($urandom));
         vals.delete();
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0)
               vals.push_back(value_type'($urandom));
            else
               vals.push_back(pool[$urandom_range(0, pool.size() - 1)]);
         end
         add_set(vals, set_idx == 3, $urandom_range(0, 3) == 0);
         random_items += n;
         set_idx++;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || staged || offering)
         @(posedge clock);
      while (expected_freqs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      while (expected_freqs.size() != 0) begin
         report_mismatch($sformatf("missing element %0d frequency %0d",
                                   expected_freqs[0].element, expected_freqs[0].frequency));
         void'(expected_freqs.pop_front());
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
sv/dvfc_pkg.sv
sv/dvfc_if.sv
sv/dvfc_cell.sv
sv/distinct_value_frequency_count.sv
tb/sv/tb_distinct_value_frequency_count.sv
